// ===== rtl/height_lattice_metropolis_site_defines.svh =====
// Assertion helpers for the checks in this block.
// Each takes a label, a condition, a consequence and a message.
// The enclosing module supplies clk and arst_n.
`ifndef HEIGHT_LATTICE_METROPOLIS_SITE_DEFINES_SVH
`define HEIGHT_LATTICE_METROPOLIS_SITE_DEFINES_SVH

// Consequence holds in the same cycle
`define HLMS_ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Consequence holds in the following cycle
`define HLMS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/hlms_pkg.sv =====
package hlms_pkg;

	// Fixed field widths
	localparam int SITE_W     = 12;
	localparam int HEIGHT_W   = 16;
	localparam int UNIFORM_W  = 32;
	localparam int COUPLING_W = 16;
	localparam int LOOP_W     = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int EXP_N_W    = 17;

	// Operation codes
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COUPLING  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_X    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_TIME = 2'd2;

	// Reset value of the coupling, 1.0 in Q4.12
	localparam logic [COUPLING_W-1:0] COUPLING_RESET = 16'd4096;

	// Exponential series terms, then the squarings
	localparam logic [4:0] TERM_T2   = 5'd0;
	localparam logic [4:0] TERM_T3   = 5'd1;
	localparam logic [4:0] TERM_T4   = 5'd2;
	localparam logic [4:0] TERM_T5   = 5'd3;
	localparam logic [4:0] TERM_LAST = 5'd20;

	// Gather slot of the center site
	localparam logic [2:0] IDX_CENTER = 3'd0;
	localparam logic [2:0] IDX_LAST   = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_DEC,
		ST_GATHER,
		ST_K,
		ST_N,
		ST_DECIDE,
		ST_EXP,
		ST_WB,
		ST_WRITE,
		ST_RESP
	} ctrl_state_t;

	typedef enum logic [1:0] {
		ES_IDLE,
		ES_MUL,
		ES_DIV,
		ES_DONE
	} exp_state_t;

	typedef struct packed {
		logic       load;
		logic       issue;
		logic [2:0] idx;
		logic       calc_k;
		logic       calc_n;
		logic       exp_start;
		logic       we;
		logic       wb;
		logic       res_load;
	} cmd_t;

	typedef struct packed {
		logic oob;
		logic op_write;
		logic op_update;
		logic hp_ok;
		logic n_le0;
		logic n_big;
		logic exp_done;
		logic below;
	} status_t;

endpackage

// ===== rtl/hlms_req_if.sv =====
interface hlms_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           operation;
	logic [hlms_pkg::SITE_W-1:0]          site;
	logic signed [hlms_pkg::HEIGHT_W-1:0] height_in;
	logic                                 step_up;
	logic [hlms_pkg::UNIFORM_W-1:0]       uniform;

	modport source(output valid, operation, site, height_in, step_up, uniform, input ready);
	modport sink(input valid, operation, site, height_in, step_up, uniform, output ready);
endinterface

// ===== rtl/hlms_res_if.sv =====
interface hlms_res_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 accepted;
	logic signed [hlms_pkg::HEIGHT_W-1:0] height_out;

	modport source(output valid, accepted, height_out, input ready);
	modport sink(input valid, accepted, height_out, output ready);
endinterface

// ===== rtl/hlms_cfg_if.sv =====
interface hlms_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [hlms_pkg::CFG_IDX_W-1:0]    index;
	logic [hlms_pkg::CFG_DATA_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/hlms_ram.sv =====
module hlms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== rtl/hlms_ctrl.sv =====
module hlms_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              res_valid,
	input  logic              res_ready,
	input  hlms_pkg::status_t status,
	output hlms_pkg::cmd_t    cmd
);

	hlms_pkg::ctrl_state_t state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       out_vld_q;

	// state, step counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hlms_pkg::ST_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.res_load) begin
				out_vld_q <= 1'b1;
			end else if (res_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_vld_q;
	assign req_ready = (state_q == hlms_pkg::ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			hlms_pkg::ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = hlms_pkg::ST_DISPATCH;
				end
			end
			hlms_pkg::ST_DISPATCH: begin
				cnt_d = '0;
				if (status.oob) begin
					state_d = hlms_pkg::ST_RESP;
				end else if (status.op_write) begin
					state_d = hlms_pkg::ST_WRITE;
				end else if (status.op_update) begin
					state_d = hlms_pkg::ST_DEC;
				end else begin
					state_d = hlms_pkg::ST_GATHER;
				end
			end
			// wait for the coordinate split pipeline
			hlms_pkg::ST_DEC: begin
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd3) begin
					cnt_d   = '0;
					state_d = hlms_pkg::ST_GATHER;
				end
			end
			// center first, then six neighbors; a read takes the center only
			hlms_pkg::ST_GATHER: begin
				cmd.idx = cnt_q[2:0];
				cnt_d   = cnt_q + 4'd1;
				if (status.op_update) begin
					cmd.issue = (cnt_q <= {1'b0, hlms_pkg::IDX_LAST});
					if (cnt_q == 4'd8) begin
						state_d = hlms_pkg::ST_K;
					end
				end else begin
					cmd.issue = (cnt_q == 4'd0);
					if (cnt_q == 4'd2) begin
						state_d = hlms_pkg::ST_RESP;
					end
				end
			end
			hlms_pkg::ST_K: begin
				cmd.calc_k = 1'b1;
				state_d    = hlms_pkg::ST_N;
			end
			hlms_pkg::ST_N: begin
				cmd.calc_n = 1'b1;
				state_d    = hlms_pkg::ST_DECIDE;
			end
			hlms_pkg::ST_DECIDE: begin
				if (!status.hp_ok || status.n_big) begin
					state_d = hlms_pkg::ST_RESP;
				end else if (status.n_le0) begin
					state_d = hlms_pkg::ST_WB;
				end else begin
					cmd.exp_start = 1'b1;
					state_d       = hlms_pkg::ST_EXP;
				end
			end
			hlms_pkg::ST_EXP: begin
				if (status.exp_done) begin
					state_d = status.below ? hlms_pkg::ST_WB : hlms_pkg::ST_RESP;
				end
			end
			hlms_pkg::ST_WB: begin
				cmd.we  = 1'b1;
				cmd.wb  = 1'b1;
				state_d = hlms_pkg::ST_RESP;
			end
			hlms_pkg::ST_WRITE: begin
				cmd.we  = 1'b1;
				state_d = hlms_pkg::ST_RESP;
			end
			hlms_pkg::ST_RESP: begin
				if (!out_vld_q || res_ready) begin
					cmd.res_load = 1'b1;
					state_d      = hlms_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hlms_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/hlms_exp.sv =====
module hlms_exp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [hlms_pkg::EXP_N_W-1:0] n,
	output logic                         done,
	output logic [31:0]                  thr
);

	hlms_pkg::exp_state_t st_q;
	logic [4:0]   tcnt_q;
	logic [2:0]   pp_q;
	logic [2:0]   dcnt_q;
	logic [63:0]  z_q, t_q, e_q, div_q;
	logic [127:0] acc_q;
	logic [63:0]  prod_s1;
	logic [1:0]   sh_s1;
	logic [2:0]   rem_q;
	logic [2:0]   dsor_q;

	logic [63:0]  a_op, b_op;
	logic [31:0]  a_h, b_h;
	logic [63:0]  prod_c;
	logic [1:0]   sh_c;
	logic [127:0] acc_add, acc_c;
	logic [63:0]  hi;
	logic [7:0]   qbits;
	logic [2:0]   rem_c;

	// operand halves for one 32x32 partial product
	always_comb begin
		a_op   = (tcnt_q <= hlms_pkg::TERM_T5) ? t_q : e_q;
		b_op   = (tcnt_q <= hlms_pkg::TERM_T5) ? z_q : e_q;
		a_h    = pp_q[0] ? a_op[63:32] : a_op[31:0];
		b_h    = pp_q[1] ? b_op[63:32] : b_op[31:0];
		prod_c = 64'(a_h) * 64'(b_h);
		sh_c   = {1'b0, pp_q[0]} + {1'b0, pp_q[1]};
	end

	// weight the registered partial product and accumulate
	always_comb begin
		case (sh_s1)
			2'd0:    acc_add = {64'd0, prod_s1};
			2'd1:    acc_add = {32'd0, prod_s1, 32'd0};
			2'd2:    acc_add = {prod_s1, 64'd0};
			default: acc_add = {64'd0, prod_s1};
		endcase
		acc_c = acc_q + acc_add;
		hi    = acc_c[127:64];
	end

	// eight quotient bits per cycle, small divisor
	always_comb begin
		logic [3:0] r;
		r     = {1'b0, rem_q};
		qbits = '0;
		for (int i = 0; i < 8; i++) begin
			r = {r[2:0], div_q[63-i]};
			if (r >= {1'b0, dsor_q}) begin
				r            = r - {1'b0, dsor_q};
				qbits[7-i]   = 1'b1;
			end
		end
		rem_c = r[2:0];
	end

	assign done = (st_q == hlms_pkg::ES_DONE);
	assign thr  = e_q[63:32];

	// control of the unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= hlms_pkg::ES_IDLE;
			tcnt_q <= '0;
			pp_q   <= '0;
			dcnt_q <= '0;
		end else begin
			case (st_q)
				hlms_pkg::ES_IDLE: begin
					if (start) begin
						st_q   <= hlms_pkg::ES_MUL;
						tcnt_q <= hlms_pkg::TERM_T2;
						pp_q   <= '0;
					end
				end
				hlms_pkg::ES_MUL: begin
					pp_q <= pp_q + 3'd1;
					if (pp_q == 3'd4) begin
						pp_q <= '0;
						case (tcnt_q)
							hlms_pkg::TERM_T2: tcnt_q <= hlms_pkg::TERM_T3;
							hlms_pkg::TERM_T4: tcnt_q <= hlms_pkg::TERM_T5;
							hlms_pkg::TERM_T3, hlms_pkg::TERM_T5: begin
								st_q   <= hlms_pkg::ES_DIV;
								dcnt_q <= '0;
							end
							default: begin
								if (tcnt_q == hlms_pkg::TERM_LAST) begin
									st_q <= hlms_pkg::ES_DONE;
								end else begin
									tcnt_q <= tcnt_q + 5'd1;
								end
							end
						endcase
					end
				end
				hlms_pkg::ES_DIV: begin
					dcnt_q <= dcnt_q + 3'd1;
					if (dcnt_q == 3'd7) begin
						st_q   <= hlms_pkg::ES_MUL;
						tcnt_q <= tcnt_q + 5'd1;
					end
				end
				hlms_pkg::ES_DONE: begin
					st_q <= hlms_pkg::ES_IDLE;
				end
				default: begin
					st_q <= hlms_pkg::ES_IDLE;
				end
			endcase
		end
	end

	// series terms, running sum and squarings
	always_ff @(posedge clk) begin
		case (st_q)
			hlms_pkg::ES_IDLE: begin
				if (start) begin
					z_q   <= {12'd0, n, 35'd0};
					t_q   <= {12'd0, n, 35'd0};
					acc_q <= '0;
				end
			end
			hlms_pkg::ES_MUL: begin
				if (pp_q != 3'd4) begin
					prod_s1 <= prod_c;
					sh_s1   <= sh_c;
				end
				if (pp_q != 3'd0) begin
					acc_q <= acc_c;
				end
				if (pp_q == 3'd4) begin
					acc_q <= '0;
					case (tcnt_q)
						hlms_pkg::TERM_T2: begin
							t_q <= hi >> 1;
							e_q <= (hi >> 1) - z_q;
						end
						hlms_pkg::TERM_T3: begin
							div_q  <= hi;
							dsor_q <= 3'd3;
							rem_q  <= '0;
						end
						hlms_pkg::TERM_T4: begin
							t_q <= hi >> 2;
							e_q <= e_q + (hi >> 2);
						end
						hlms_pkg::TERM_T5: begin
							div_q  <= hi;
							dsor_q <= 3'd5;
							rem_q  <= '0;
						end
						default: begin
							e_q <= hi;
						end
					endcase
				end
			end
			hlms_pkg::ES_DIV: begin
				div_q <= {div_q[55:0], qbits};
				rem_q <= rem_c;
				if (dcnt_q == 3'd7) begin
					t_q <= {div_q[55:0], qbits};
					e_q <= e_q - {div_q[55:0], qbits};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/hlms_dp.sv =====
module hlms_dp #(
	parameter int SIDE        = 16,
	parameter int HEIGHT_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [1:0]                            operation,
	input  logic [hlms_pkg::SITE_W-1:0]           site,
	input  logic signed [hlms_pkg::HEIGHT_W-1:0]  height_in,
	input  logic                                  step_up,
	input  logic [hlms_pkg::UNIFORM_W-1:0]        uniform,
	input  logic                                  cfg_we,
	input  logic [hlms_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hlms_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  hlms_pkg::cmd_t                        cmd,
	output hlms_pkg::status_t                     status,
	output logic                                  res_accepted,
	output logic signed [hlms_pkg::HEIGHT_W-1:0]  res_height
);

	localparam int VOL = SIDE * SIDE * SIDE;
	localparam int SS  = SIDE * SIDE;
	localparam int AW  = $clog2(VOL);
	localparam int CW  = $clog2(SIDE);
	localparam int HB  = HEIGHT_BITS;
	localparam int SW  = HB + 3;
	localparam int KW  = HB + 5;
	localparam int NW  = KW + 17;
	localparam int STW = hlms_pkg::SITE_W;
	// reciprocals for splitting the site index, exact for 12-bit sites
	localparam int S0  = STW + $clog2(SS);
	localparam int M0  = ((1 << S0) + SS - 1) / SS;
	localparam int S1  = STW + CW;
	localparam int M1  = ((1 << S1) + SIDE - 1) / SIDE;
	localparam int PW0 = S0 + CW;
	localparam int PW1 = S1 + CW;
	localparam logic signed [KW-1:0] K_THREE = KW'(3);
	localparam logic signed [HB-1:0] H_MAX   = {1'b0, {(HB-1){1'b1}}};
	localparam logic signed [HB-1:0] H_MIN   = {1'b1, {(HB-1){1'b0}}};

	// configuration
	logic [hlms_pkg::COUPLING_W-1:0] coupling_q;
	logic [hlms_pkg::LOOP_W-1:0]     loop_x_q, loop_t_q;

	// request
	logic [1:0]                      op_q;
	logic [STW-1:0]                  site_q;
	logic                            up_q;
	logic [hlms_pkg::UNIFORM_W-1:0]  uniform_q;

	// coordinate split
	logic [CW-1:0]  x0_s1, x1_s3, x2_s4;
	logic [STW-1:0] r0_s2;
	logic [PW0-1:0] p0;
	logic [PW1-1:0] p1;

	// gather
	logic [AW-1:0]  site_addr, addr_c, addr_s1, ram_addr;
	logic           vld_s1, vld_s2;
	logic [2:0]     idx_s1, idx_s2;
	logic [CW-1:0]  a0, a1, a2, x0p, x0m, x1p, x1m, x2p, x2m;
	logic [HB-1:0]  rdata, wdata;

	// arithmetic
	logic signed [HB-1:0] h_q, hp;
	logic signed [SW-1:0] sum_q;
	logic signed [KW-1:0] k_q, k_c, h_k, sum_k, h6;
	logic signed [NW-1:0] n_q, n_c;
	logic signed [1:0]    adj;
	logic                 in_loop;
	logic                 acc_q;
	logic                 exp_done;
	logic [31:0]          thr;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coupling_q <= hlms_pkg::COUPLING_RESET;
			loop_x_q   <= '0;
			loop_t_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				hlms_pkg::CFG_COUPLING:  coupling_q <= cfg_data;
				hlms_pkg::CFG_LOOP_X:    loop_x_q   <= cfg_data[hlms_pkg::LOOP_W-1:0];
				hlms_pkg::CFG_LOOP_TIME: loop_t_q   <= cfg_data[hlms_pkg::LOOP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= operation;
			site_q    <= site;
			up_q      <= step_up;
			uniform_q <= uniform;
		end
	end

	// split site into x0, x1, x2 over four stages
	assign p0 = PW0'(site_q) * PW0'(M0);
	assign p1 = PW1'(r0_s2) * PW1'(M1);
	always_ff @(posedge clk) begin
		x0_s1 <= p0[S0 +: CW];
		r0_s2 <= site_q - STW'(STW'(x0_s1) * STW'(SS));
		x1_s3 <= p1[S1 +: CW];
		x2_s4 <= CW'(r0_s2 - STW'(STW'(x1_s3) * STW'(SIDE)));
	end

	// periodic neighbors
	always_comb begin
		x0p = (x0_s1 == CW'(SIDE - 1)) ? '0 : x0_s1 + CW'(1);
		x0m = (x0_s1 == '0) ? CW'(SIDE - 1) : x0_s1 - CW'(1);
		x1p = (x1_s3 == CW'(SIDE - 1)) ? '0 : x1_s3 + CW'(1);
		x1m = (x1_s3 == '0) ? CW'(SIDE - 1) : x1_s3 - CW'(1);
		x2p = (x2_s4 == CW'(SIDE - 1)) ? '0 : x2_s4 + CW'(1);
		x2m = (x2_s4 == '0) ? CW'(SIDE - 1) : x2_s4 - CW'(1);
		a0  = x0_s1;
		a1  = x1_s3;
		a2  = x2_s4;
		case (cmd.idx)
			3'd1:    a0 = x0p;
			3'd2:    a0 = x0m;
			3'd3:    a1 = x1p;
			3'd4:    a1 = x1m;
			3'd5:    a2 = x2p;
			3'd6:    a2 = x2m;
			default: a0 = x0_s1;
		endcase
		addr_c = AW'(a0) * AW'(SS) + AW'(a1) * AW'(SIDE) + AW'(a2);
	end

	assign site_addr = AW'(site_q);

	// read pipeline: address register, then memory output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= (cmd.idx == hlms_pkg::IDX_CENTER) ? site_addr : addr_c;
		idx_s1  <= cmd.idx;
		idx_s2  <= idx_s1;
	end

	assign ram_addr = cmd.we ? site_addr : addr_s1;
	assign wdata    = cmd.wb ? hp : h_q;

	hlms_ram #(
		.WIDTH (HB),
		.DEPTH (VOL)
	) u_ram (
		.clk   (clk),
		.we    (cmd.we),
		.addr  (ram_addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	// site height and neighbor sum
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			h_q   <= HB'(height_in);
			sum_q <= '0;
		end else if (cmd.wb) begin
			h_q <= hp;
		end else if (vld_s2) begin
			if (idx_s2 == hlms_pkg::IDX_CENTER) begin
				h_q <= signed'(rdata);
			end else begin
				sum_q <= sum_q + SW'(signed'(rdata));
			end
		end
	end

	// dislocation on axis 1 inside the loop
	always_comb begin
		in_loop = (8'(x0_s1) < 8'(loop_x_q)) ||
			((8'(x0_s1) == 8'(loop_x_q)) && (8'(x2_s4) < 8'(loop_t_q)));
		adj = 2'sd0;
		if (in_loop && (x1_s3 == CW'(0))) begin
			adj = 2'sd1;
		end else if (in_loop && (x1_s3 == CW'(1))) begin
			adj = -2'sd1;
		end
	end

	// K = 6*h*d + 3 - d*sum
	always_comb begin
		h_k   = KW'(h_q);
		sum_k = KW'(sum_q) + KW'(adj);
		h6    = (h_k <<< 2) + (h_k <<< 1);
		k_c   = up_q ? (h6 + K_THREE - sum_k) : (K_THREE + sum_k - h6);
		n_c   = NW'(signed'({1'b0, coupling_q})) * NW'(k_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_k) begin
			k_q <= k_c;
		end
		if (cmd.calc_n) begin
			n_q <= n_c;
		end
	end

	assign hp = up_q ? h_q + HB'(1) : h_q - HB'(1);

	hlms_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.exp_start),
		.n      (n_q[hlms_pkg::EXP_N_W-1:0]),
		.done   (exp_done),
		.thr    (thr)
	);

	// status to the controller; operation code 3 is served as a read
	always_comb begin
		status.oob       = (32'(site_q) >= 32'(VOL));
		status.op_write  = (op_q == hlms_pkg::OP_WRITE);
		status.op_update = (op_q == hlms_pkg::OP_UPDATE);
		status.hp_ok     = !((up_q && (h_q == H_MAX)) || (!up_q && (h_q == H_MIN)));
		status.n_le0     = n_q[NW-1] || (n_q == '0);
		status.n_big     = !n_q[NW-1] && (n_q[NW-2:hlms_pkg::EXP_N_W] != '0);
		status.exp_done  = exp_done;
		status.below     = (uniform_q < thr);
	end

	// accept flag and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 1'b0;
		end else if (cmd.load) begin
			acc_q <= 1'b0;
		end else if (cmd.wb) begin
			acc_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_accepted <= acc_q;
			res_height   <= status.oob ? '0 : hlms_pkg::HEIGHT_W'(h_q);
		end
	end

endmodule

// ===== rtl/height_lattice_metropolis_site.sv =====
// Metropolis site update on a periodic SIDE^3 lattice of signed heights held in one
// single-port memory. One request at a time. When the action change lands between
// 0 and 32, the exponential unit adds 21 products of 64x64 bits on one 32x32
// multiplier and two divisions. The seven lattice reads go one per cycle through
// the memory port. A finished result waits in the output register while the next
// request is taken. Configuration writes are taken at any time and belong only
// between requests. The memory has no reset.
module height_lattice_metropolis_site #(
	parameter int SIDE        = 16,
	parameter int HEIGHT_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	hlms_req_if.sink   req,
	hlms_res_if.source res,
	hlms_cfg_if.sink   cfg
);

	`include "height_lattice_metropolis_site_defines.svh"

	hlms_pkg::cmd_t    cmd;
	hlms_pkg::status_t status;

	assign cfg.ready = 1'b1;

	hlms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.status    (status),
		.cmd       (cmd)
	);

	hlms_dp #(
		.SIDE        (SIDE),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.operation    (req.operation),
		.site         (req.site),
		.height_in    (req.height_in),
		.step_up      (req.step_up),
		.uniform      (req.uniform),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.cmd          (cmd),
		.status       (status),
		.res_accepted (res.accepted),
		.res_height   (res.height_out)
	);

	// checks
	`HLMS_ASSERT_NEXT(a_busy_after_req, req.valid && req.ready, !req.ready, "request taken while busy")
	`HLMS_ASSERT_SAME(a_no_write_idle, cmd.we, !req.ready, "memory write while idle")
	`HLMS_ASSERT_NEXT(a_result_shown, cmd.res_load, res.valid, "loaded result not offered")
	`HLMS_ASSERT_SAME(a_exp_alone, cmd.exp_start, !cmd.we && !cmd.issue, "exp start overlaps memory use")

endmodule

// ===== tb/sv/height_lattice_metropolis_site_check.sv =====
import hlms_pkg::*;

module height_lattice_metropolis_site_check (
	input  logic clk,
	input  logic arst_n,
	hlms_req_if  req,
	hlms_res_if  res,
	hlms_cfg_if  cfg,
	output int   errors,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic                accepted;
		logic signed [15:0]  height_out;
	} site_result_t;

	logic signed [15:0] lattice [0:4095];
	logic [15:0]        coupling;
	logic [4:0]         loop_x;
	logic [4:0]         loop_t;
	site_result_t       result_q [$];

	// High half of a 64x64 product
	function automatic logic [63:0] mul_top(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[127:64];
	endfunction

	// 2^32 * exp(-n/4096), truncated series then 17 squarings
	function automatic logic [31:0] boltzmann_limit(input logic [63:0] n);
		logic [63:0] z, t2, t3, t4, t5, e;
		z = n << 35;
		t2 = mul_top(z, z) >> 1;
		t3 = mul_top(t2, z) / 3;
		t4 = mul_top(t3, z) / 4;
		t5 = mul_top(t4, z) / 5;
		e = 64'd0 - z + t2 - t3 + t4 - t5;
		for (int i = 0; i < 17; i++)
			e = mul_top(e, e);
		return e[63:32];
	endfunction

	// Apply one request to the lattice copy and return its response
	function automatic site_result_t predict_site_op(input logic [1:0] op,
			input logic [11:0] site, input logic signed [15:0] hin,
			input logic step, input logic [31:0] uni);
		site_result_t r;
		logic [3:0] x0, x1, x2;
		longint h, d, hp, f1, b1, sum, k, n;
		logic in_loop, take;
		x0 = site[11:8];
		x1 = site[7:4];
		x2 = site[3:0];
		r.accepted = 1'b0;
		if (op == OP_WRITE) begin
			lattice[site] = hin;
		end else if (op == OP_UPDATE) begin
			h = lattice[site];
			d = step ? 1 : -1;
			hp = h + d;
			f1 = lattice[{x0, x1 + 4'd1, x2}];
			b1 = lattice[{x0, x1 - 4'd1, x2}];
			in_loop = ({1'b0, x0} < loop_x) || ({1'b0, x0} == loop_x && {1'b0, x2} < loop_t);
			if (in_loop) begin
				if (x1 == 4'd0)
					f1 += 1;
				else if (x1 == 4'd1)
					b1 -= 1;
			end
			sum = longint'(lattice[{x0 + 4'd1, x1, x2}]) + longint'(lattice[{x0 - 4'd1, x1, x2}])
				+ f1 + b1
				+ longint'(lattice[{x0, x1, x2 + 4'd1}]) + longint'(lattice[{x0, x1, x2 - 4'd1}]);
			if (hp >= -32768 && hp <= 32767) begin
				k = 6 * h * d + 3 - d * sum;
				n = longint'({48'd0, coupling}) * k;
				if (n <= 0)
					take = 1'b1;
				else if (n >= (64'sd1 <<< 17))
					take = 1'b0;
				else
					take = uni < boltzmann_limit(n);
				if (take) begin
					lattice[site] = hp[15:0];
					r.accepted = 1'b1;
				end
			end
		end
		r.height_out = lattice[site];
		return r;
	endfunction

	assign outstanding = result_q.size();

	// Watch all three channels
	always @(posedge clk or negedge arst_n) begin
		site_result_t want;
		if (!arst_n) begin
			coupling <= COUPLING_RESET;
			loop_x <= '0;
			loop_t <= '0;
			errors <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_COUPLING: coupling <= cfg.data;
					CFG_LOOP_X: loop_x <= cfg.data[4:0];
					CFG_LOOP_TIME: loop_t <= cfg.data[4:0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				if (result_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected response: accepted=%0b height=%0d",
							res.accepted, res.height_out);
					errors <= errors + 1;
				end else begin
					want = result_q.pop_front();
					if (want.accepted !== res.accepted || want.height_out !== res.height_out) begin
						if (errors < 10)
							$display("mismatch: accepted exp %0b got %0b, height exp %0d got %0d",
								want.accepted, res.accepted, want.height_out, res.height_out);
						errors <= errors + 1;
					end
				end
			end
			if (req.valid && req.ready)
				result_q.push_back(predict_site_op(req.operation, req.site, req.height_in,
					req.step_up, req.uniform));
		end
	end
endmodule

// ===== tb/sv/height_lattice_metropolis_site_test.sv =====
import hlms_pkg::*;

module height_lattice_metropolis_site_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic calm = 1'b0;
	int   errors, outstanding;
	int   cycles = 0;
	bit   written [0:4095];

	hlms_req_if req();
	hlms_res_if res();
	hlms_cfg_if cfg();

	height_lattice_metropolis_site u_top (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .res(res.source), .cfg(cfg.sink)
	);

	height_lattice_metropolis_site_check u_check (
		.clk(clk), .arst_n(arst_n), .req(req), .res(res), .cfg(cfg),
		.errors(errors), .outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Response stalls
	always @(posedge clk)
		res.ready <= calm || ($urandom_range(99) >= 32);

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_request(input logic [1:0] op, input logic [11:0] site,
			input logic signed [15:0] hin, input logic step, input logic [31:0] uni);
		if (!calm && $urandom_range(99) < 32) begin
			req.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 32);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.site <= site;
		req.height_in <= hin;
		req.step_up <= step;
		req.uniform <= uni;
		do @(posedge clk); while (!req.ready);
		if (op == OP_WRITE)
			written[site] = 1'b1;
	endtask

	task automatic put_height(input logic [11:0] site, input logic signed [15:0] v);
		send_request(OP_WRITE, site, v, 1'($urandom_range(1)), $urandom);
	endtask

	function automatic logic signed [15:0] near_zero();
		return 16'($signed($urandom_range(8)) - 4);
	endfunction

	// Make sure a site and, for updates, its six neighbors hold written values
	task automatic prime_site(input logic [11:0] s, input bit with_neighbors);
		logic [11:0] n [0:6];
		n[0] = s;
		n[1] = {s[11:8] + 4'd1, s[7:0]};
		n[2] = {s[11:8] - 4'd1, s[7:0]};
		n[3] = {s[11:8], s[7:4] + 4'd1, s[3:0]};
		n[4] = {s[11:8], s[7:4] - 4'd1, s[3:0]};
		n[5] = {s[11:4], s[3:0] + 4'd1};
		n[6] = {s[11:4], s[3:0] - 4'd1};
		for (int i = 0; i < (with_neighbors ? 7 : 1); i++)
			if (!written[n[i]])
				put_height(n[i], near_zero());
	endtask

	task automatic update_site(input logic [11:0] s, input logic step, input logic [31:0] uni);
		prime_site(s, 1'b1);
		send_request(OP_UPDATE, s, 16'($urandom), step, uni);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_requests(input int count);
		logic [11:0] s;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			s = 12'($urandom);
			// stay in a small block across the loop seam so priming stays short
			s[11] = 1'b0;
			s[7:6] = 2'd0;
			s[3] = 1'b0;
			// keep some traffic near the loop seam
			if ($urandom_range(3) == 0)
				s[7:5] = 3'd0;
			if (r < 22)
				put_height(s, ($urandom_range(7) == 0) ? 16'($urandom) : near_zero());
			else if (r < 35) begin
				prime_site(s, 1'b0);
				send_request(($urandom_range(3) == 0) ? 2'd3 : OP_READ, s, 16'($urandom),
					1'($urandom_range(1)), $urandom);
			end else
				update_site(s, 1'($urandom_range(1)), $urandom);
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.operation = OP_READ;
		req.site = '0;
		req.height_in = '0;
		req.step_up = 1'b0;
		req.uniform = '0;
		cfg.valid = 1'b0;
		cfg.index = CFG_COUPLING;
		cfg.data = '0;
		res.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: height extremes, overflow rejection, reads, unused code
		put_height(12'd0, 16'sd32767);
		update_site(12'd0, 1'b1, 32'd0);
		update_site(12'd0, 1'b0, 32'hFFFF_FFFF);
		put_height(12'd4095, -16'sd32768);
		update_site(12'd4095, 1'b0, 32'd0);
		update_site(12'd4095, 1'b1, 32'd0);
		send_request(OP_READ, 12'd4095, 16'sd0, 1'b0, 32'd0);
		send_request(2'd3, 12'd0, -16'sd1, 1'b1, 32'hFFFF_FFFF);
		put_height(12'h555, 16'sd0);
		update_site(12'h555, 1'b1, 32'd0);
		update_site(12'h555, 1'b1, 32'hFFFF_FFFF);
		update_site(12'hAAA, 1'b0, 32'h8000_0000);
		update_site(12'h010, 1'b1, 32'h0000_0001);
		drain();

		// Register settings, extremes included, with random traffic in each
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: ;
				1: begin
					write_reg(CFG_COUPLING, 16'd0);
					write_reg(CFG_LOOP_X, 16'd16);
					write_reg(CFG_LOOP_TIME, 16'd16);
				end
				2: begin
					write_reg(CFG_COUPLING, 16'hFFFF);
					write_reg(CFG_LOOP_X, 16'd0);
					write_reg(CFG_LOOP_TIME, 16'd0);
				end
				3: begin
					write_reg(CFG_COUPLING, 16'd1);
					write_reg(CFG_LOOP_X, 16'd3);
					write_reg(CFG_LOOP_TIME, 16'd7);
				end
				default: begin
					write_reg(CFG_COUPLING, 16'($urandom_range(12000)));
					write_reg(CFG_LOOP_X, 16'($urandom_range(16)));
					write_reg(CFG_LOOP_TIME, 16'($urandom_range(16)));
				end
			endcase
			calm = (ph == 4);
			random_requests(90);
			drain();
		end
		calm = 1'b0;

		repeat (200) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
